FILE: hdl/necir_pkg.sv
// Shared types and constants for the NEC infrared frame decoder.
`timescale 1ns / 1ps

package necir_pkg;

    // Width of the nominal NEC durations and of the margin register.
    localparam int NOM_W    = 14;
    localparam int MARGIN_W = 10;
    localparam int COUNT_W  = 7;
    localparam int CODE_W   = 16;

    // Nominal NEC timings in microsecond ticks.
    localparam logic [NOM_W-1:0] LEAD_MARK  = 14'd9000;
    localparam logic [NOM_W-1:0] LEAD_SPACE = 14'd4500;
    localparam logic [NOM_W-1:0] REP_SPACE  = 14'd2250;
    localparam logic [NOM_W-1:0] BIT_MARK   = 14'd560;
    localparam logic [NOM_W-1:0] ZERO_SPACE = 14'd560;
    localparam logic [NOM_W-1:0] ONE_SPACE  = 14'd1690;

    // Frame lengths and symbol counter limits.
    localparam logic [COUNT_W-1:0] FRAME_LEN     = 7'd34;
    localparam logic [COUNT_W-1:0] REPEAT_LEN    = 7'd2;
    localparam logic [COUNT_W-1:0] LAST_DATA_IDX = 7'd32;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 7'd127;

    // Configuration register map (word index) and reset value.
    localparam logic                REG_MARGIN   = 1'b0;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd300;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_NORMAL  = 2'd0,
        STATUS_REPEAT  = 2'd1,
        STATUS_INVALID = 2'd2,
        STATUS_UNKNOWN = 2'd3
    } status_t;

    // Timing matches of one symbol against the NEC symbol shapes.
    typedef struct packed {
        logic lead;
        logic rep;
        logic one;
        logic zero;
    } match_t;

endpackage

FILE: hdl/necir_symbol_match.sv
// Window comparisons of one symbol against the NEC leader, repeat and bit timings.
`timescale 1ns / 1ps

module necir_symbol_match #(
    parameter int DURATION_BITS = 15
) (
    input  logic [necir_pkg::MARGIN_W-1:0] margin,
    input  logic [DURATION_BITS-1:0]       mark_us,
    input  logic [DURATION_BITS-1:0]       space_us,
    output necir_pkg::match_t              match
);

    // Compare width: holds a duration plus the margin, and a nominal plus the margin.
    localparam int CMP_W = ((DURATION_BITS > necir_pkg::NOM_W) ?
                            DURATION_BITS : necir_pkg::NOM_W) + 1;

    logic [CMP_W-1:0] mark_w;
    logic [CMP_W-1:0] space_w;
    logic [CMP_W-1:0] margin_w;

    // Strict window: nom - m < v < nom + m, with the lower bound moved to the
    // left side so that a margin above the nominal drops the lower bound.
    function automatic logic in_window(input logic [CMP_W-1:0] v,
                                       input logic [necir_pkg::NOM_W-1:0] nom,
                                       input logic [CMP_W-1:0] m);
        logic [CMP_W-1:0] nom_w;
        logic [CMP_W-1:0] upper;
        logic [CMP_W-1:0] v_plus;
        nom_w  = {{(CMP_W-necir_pkg::NOM_W){1'b0}}, nom};
        upper  = nom_w + m;
        v_plus = v + m;
        return (v < upper) && (v_plus > nom_w);
    endfunction

    assign mark_w   = {{(CMP_W-DURATION_BITS){1'b0}}, mark_us};
    assign space_w  = {{(CMP_W-DURATION_BITS){1'b0}}, space_us};
    assign margin_w = {{(CMP_W-necir_pkg::MARGIN_W){1'b0}}, margin};

    // Both halves of the symbol must fall in their windows.
    always_comb
    begin
        match.lead = in_window(mark_w, necir_pkg::LEAD_MARK, margin_w) &&
                     in_window(space_w, necir_pkg::LEAD_SPACE, margin_w);
        match.rep  = in_window(mark_w, necir_pkg::LEAD_MARK, margin_w) &&
                     in_window(space_w, necir_pkg::REP_SPACE, margin_w);
        match.one  = in_window(mark_w, necir_pkg::BIT_MARK, margin_w) &&
                     in_window(space_w, necir_pkg::ONE_SPACE, margin_w);
        match.zero = in_window(mark_w, necir_pkg::BIT_MARK, margin_w) &&
                     in_window(space_w, necir_pkg::ZERO_SPACE, margin_w);
    end

endmodule

FILE: hdl/necir_frame_state.sv
// Frame state update, stored code and registered result word of the decoder.
`timescale 1ns / 1ps

module necir_frame_state (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            word_valid,
    input  logic                            word_end,
    input  necir_pkg::match_t               match,
    output logic                            take,
    output logic                            res_valid,
    input  logic                            res_stall,
    output necir_pkg::status_t              res_status,
    output logic [necir_pkg::CODE_W-1:0]    res_address,
    output logic [necir_pkg::CODE_W-1:0]    res_command
);

    logic [necir_pkg::COUNT_W-1:0]  count_reg, count_next, count_inc;
    logic [2*necir_pkg::CODE_W-1:0] shift_reg, shift_next, shift_upd;
    logic                           good_reg, good_next, good_upd;
    logic                           rep_reg, rep_next, rep_upd;
    logic [necir_pkg::CODE_W-1:0]   stored_addr_reg, stored_addr_next;
    logic [necir_pkg::CODE_W-1:0]   stored_cmd_reg, stored_cmd_next;
    logic                           res_valid_reg, res_valid_next;
    necir_pkg::status_t             res_status_reg, res_status_next;
    logic [necir_pkg::CODE_W-1:0]   res_addr_reg, res_addr_next;
    logic [necir_pkg::CODE_W-1:0]   res_cmd_reg, res_cmd_next;
    logic                           load_res;

    // A word that ends a frame needs a free result register; others always pass.
    assign take     = word_valid && (!word_end || !res_valid_reg || !res_stall);
    assign load_res = take && word_end;

    // Symbol checks: the leader on the first symbol, data bits on the next 32.
    always_comb
    begin
        good_upd  = good_reg;
        rep_upd   = rep_reg;
        shift_upd = shift_reg;
        if (count_reg == '0)
        begin
            good_upd = good_reg && match.lead;
            rep_upd  = match.rep;
        end
        else if (count_reg <= necir_pkg::LAST_DATA_IDX)
        begin
            good_upd  = good_reg && (match.one || match.zero);
            shift_upd = {match.one, shift_reg[2*necir_pkg::CODE_W-1:1]};
        end
        count_inc = (count_reg == necir_pkg::COUNT_MAX) ?
                    count_reg : count_reg + 1'b1;
    end

    // Next state, stored code and the result word of a finished frame.
    always_comb
    begin
        count_next       = count_reg;
        shift_next       = shift_reg;
        good_next        = good_reg;
        rep_next         = rep_reg;
        stored_addr_next = stored_addr_reg;
        stored_cmd_next  = stored_cmd_reg;
        res_status_next  = necir_pkg::STATUS_UNKNOWN;
        res_addr_next    = '0;
        res_cmd_next     = '0;
        if (take)
        begin
            if (word_end)
            begin
                count_next = '0;
                shift_next = '0;
                good_next  = 1'b1;
                rep_next   = 1'b0;
                if (count_inc == necir_pkg::FRAME_LEN)
                begin
                    if (good_upd)
                    begin
                        stored_addr_next = shift_upd[necir_pkg::CODE_W-1:0];
                        stored_cmd_next  = shift_upd[2*necir_pkg::CODE_W-1:necir_pkg::CODE_W];
                        res_status_next  = necir_pkg::STATUS_NORMAL;
                        res_addr_next    = shift_upd[necir_pkg::CODE_W-1:0];
                        res_cmd_next     = shift_upd[2*necir_pkg::CODE_W-1:necir_pkg::CODE_W];
                    end
                    else
                    begin
                        res_status_next = necir_pkg::STATUS_INVALID;
                    end
                end
                else if (count_inc == necir_pkg::REPEAT_LEN)
                begin
                    if (rep_upd)
                    begin
                        res_status_next = necir_pkg::STATUS_REPEAT;
                        res_addr_next   = stored_addr_reg;
                        res_cmd_next    = stored_cmd_reg;
                    end
                    else
                    begin
                        res_status_next = necir_pkg::STATUS_INVALID;
                    end
                end
            end
            else
            begin
                count_next = count_inc;
                shift_next = shift_upd;
                good_next  = good_upd;
                rep_next   = rep_upd;
            end
        end
    end

    // Result valid: set by a finished frame, cleared once the word is taken.
    always_comb
    begin
        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control state and stored code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            shift_reg       <= '0;
            good_reg        <= 1'b1;
            rep_reg         <= 1'b0;
            stored_addr_reg <= '0;
            stored_cmd_reg  <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            shift_reg       <= shift_next;
            good_reg        <= good_next;
            rep_reg         <= rep_next;
            stored_addr_reg <= stored_addr_next;
            stored_cmd_reg  <= stored_cmd_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Result payload, loaded only with a new result word.
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_status_reg <= res_status_next;
            res_addr_reg   <= res_addr_next;
            res_cmd_reg    <= res_cmd_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_status  = res_status_reg;
    assign res_address = res_addr_reg;
    assign res_command = res_cmd_reg;

endmodule

FILE: hdl/nec_ir_frame_decoder.sv
// Top level of the NEC infrared frame decoder: config port, input register, result path.
`timescale 1ns / 1ps
//
// The decoder takes one received pulse symbol per word on the symbol channel
// (sym_valid / sym_stall with mark_us, space_us, frame_end) and returns one
// result word on the result channel (res_valid / res_stall with status,
// address, command) for every symbol word that has frame_end set.
// Symbols without frame_end give no result word.
// A symbol word is captured in an input register; on the next cycle the
// window comparisons and frame state update run, and the result is written
// to the result register. Throughput is one symbol word per cycle while
// sym_stall stays low, set by the single compare and update pass between
// the input and result registers.
// The tolerance margin_us is written through the APB port at word 0
// (byte address 0); reads return it. Write it only while the decoder is idle.
// Reset clears the frame state, the stored code and both valid flags, and
// loads the margin with 300 ticks.
// While the receiver stalls, the result word holds. Symbols without frame_end
// still flow through; an end symbol waits in the input register, which then
// raises sym_stall until the result register frees up.
//

module nec_ir_frame_decoder #(
    parameter int DURATION_BITS = 15
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // Symbol channel
    input  logic                     sym_valid,
    output logic                     sym_stall,
    input  logic [DURATION_BITS-1:0] mark_us,
    input  logic [DURATION_BITS-1:0] space_us,
    input  logic                     frame_end,
    // Result channel
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [1:0]               status,
    output logic [15:0]              address,
    output logic [15:0]              command
);

    logic [necir_pkg::MARGIN_W-1:0] margin_reg;
    logic                           s1_valid_reg;
    logic [DURATION_BITS-1:0]       s1_mark_reg;
    logic [DURATION_BITS-1:0]       s1_space_reg;
    logic                           s1_end_reg;
    logic                           take;
    logic                           cfg_write;
    necir_pkg::match_t              match;
    necir_pkg::status_t             res_status;

    // Configuration register: word index taken from the upper address bit.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == necir_pkg::REG_MARGIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= necir_pkg::MARGIN_RESET;
        end
        else if (cfg_write)
        begin
            margin_reg <= pwdata[necir_pkg::MARGIN_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == necir_pkg::REG_MARGIN)
        begin
            prdata = {{(32-necir_pkg::MARGIN_W){1'b0}}, margin_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Input register: stalls only while it holds a word that cannot move on.
    assign sym_stall = s1_valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!sym_stall)
        begin
            s1_valid_reg <= sym_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym_valid && !sym_stall)
        begin
            s1_mark_reg  <= mark_us;
            s1_space_reg <= space_us;
            s1_end_reg   <= frame_end;
        end
    end

    // Timing checks of the registered symbol.
    necir_symbol_match #(
        .DURATION_BITS(DURATION_BITS)
    ) u_match (
        .margin   (margin_reg),
        .mark_us  (s1_mark_reg),
        .space_us (s1_space_reg),
        .match    (match)
    );

    // Frame state and result register.
    necir_frame_state u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (s1_valid_reg),
        .word_end    (s1_end_reg),
        .match       (match),
        .take        (take),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_status  (res_status),
        .res_address (address),
        .res_command (command)
    );

    assign status = res_status;

endmodule

FILE: hdl/necir_checker.sv
// Port-level assertions for the NEC infrared frame decoder, bound to the top level.
`timescale 1ns / 1ps

module necir_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sym_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [1:0]  status,
    input logic [15:0] address,
    input logic [15:0] command
);

    // A stalled result word stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=>
            res_valid && $stable(status) && $stable(address) && $stable(command))
    else $error("result word changed while stalled");

    // Invalid and unknown frames carry a zero code.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == necir_pkg::STATUS_INVALID ||
                      status == necir_pkg::STATUS_UNKNOWN)
            |-> address == '0 && command == '0)
    else $error("code not cleared on a failed frame");

    // Symbols are held back only by a full, stalled result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        sym_stall |-> res_valid && res_stall)
    else $error("symbol channel stalled with a free result register");

endmodule

bind nec_ir_frame_decoder necir_checker u_necir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sym_stall (sym_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .address   (address),
    .command   (command)
);

FILE: tb/nec_ir_frame_decoder_tb.sv
// Self-checking testbench for the NEC infrared frame decoder with a built-in frame decode model.
`timescale 1ns / 1ps

module nec_ir_frame_decoder_tb;

    localparam int DW           = 15;
    localparam int DUR_MAX      = 32767;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 140;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    // One decoded result word as the decoder should return it.
    typedef struct {
        necir_pkg::status_t st;
        logic [15:0]        addr;
        logic [15:0]        cmd;
    } nec_code_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          sym_valid;
    logic          sym_stall;
    logic [DW-1:0] mark_us;
    logic [DW-1:0] space_us;
    logic          frame_end;
    logic          res_valid;
    logic          res_stall;
    logic [1:0]    status;
    logic [15:0]   address;
    logic [15:0]   command;

    // Model state of the decoder.
    logic [necir_pkg::MARGIN_W-1:0] margin_q;
    logic [necir_pkg::COUNT_W-1:0]  sym_cnt;
    logic [31:0]                    data_sr;
    bit                             frame_ok;
    bit                             lead_is_repeat;
    logic [15:0]                    kept_addr;
    logic [15:0]                    kept_cmd;

    nec_code_t expected_codes[$];
    nec_code_t oldest_code;
    int        errors;
    int        cycles;
    int        symbols_sent;
    bit        tx_idle_en;
    bit        rx_idle_en;
    bit        hold_req;
    int        hold_cnt;
    int        rx_run;

    nec_ir_frame_decoder #(
        .DURATION_BITS(DW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .mark_us   (mark_us),
        .space_us  (space_us),
        .frame_end (frame_end),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .address   (address),
        .command   (command)
    );

    // Clock: 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Cycle counter with a run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("nec_ir_frame_decoder_tb: FAIL");
            $finish;
        end
    end

    // Random gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 96)
            return $urandom_range(12, 4);
        return $urandom_range(70, 25);
    endfunction

    // Strict tolerance window; the lower bound may go below zero.
    function automatic bit in_window(int d, int nom);
        int m;
        m = int'(margin_q);
        return (d < nom + m) && (d > nom - m);
    endfunction

    function automatic bit shape_match(int mk, int sp, int nm, int ns);
        return in_window(mk, nm) && in_window(sp, ns);
    endfunction

    // Advance the frame model by one symbol and queue the result it causes.
    function automatic void decode_symbol(logic [DW-1:0] mk, logic [DW-1:0] sp, logic fe);
        nec_code_t w;
        int        mv;
        int        sv;
        bit        b;
        mv = int'(mk);
        sv = int'(sp);
        if (sym_cnt == 0)
        begin
            frame_ok = frame_ok && shape_match(mv, sv, int'(necir_pkg::LEAD_MARK),
                                               int'(necir_pkg::LEAD_SPACE));
            lead_is_repeat = shape_match(mv, sv, int'(necir_pkg::LEAD_MARK),
                                         int'(necir_pkg::REP_SPACE));
        end
        else if (sym_cnt <= necir_pkg::LAST_DATA_IDX)
        begin
            b = 1'b0;
            // A symbol that fits both data shapes counts as a one.
            if (shape_match(mv, sv, int'(necir_pkg::BIT_MARK), int'(necir_pkg::ONE_SPACE)))
                b = 1'b1;
            else if (!shape_match(mv, sv, int'(necir_pkg::BIT_MARK),
                                  int'(necir_pkg::ZERO_SPACE)))
                frame_ok = 1'b0;
            data_sr = {b, data_sr[31:1]};
        end
        if (sym_cnt < necir_pkg::COUNT_MAX)
            sym_cnt++;
        if (!fe)
            return;

        w.st   = necir_pkg::STATUS_UNKNOWN;
        w.addr = '0;
        w.cmd  = '0;
        if (sym_cnt == necir_pkg::FRAME_LEN)
        begin
            if (frame_ok)
            begin
                kept_addr = data_sr[15:0];
                kept_cmd  = data_sr[31:16];
                w.st   = necir_pkg::STATUS_NORMAL;
                w.addr = kept_addr;
                w.cmd  = kept_cmd;
            end
            else
                w.st = necir_pkg::STATUS_INVALID;
        end
        else if (sym_cnt == necir_pkg::REPEAT_LEN)
        begin
            if (lead_is_repeat)
            begin
                w.st   = necir_pkg::STATUS_REPEAT;
                w.addr = kept_addr;
                w.cmd  = kept_cmd;
            end
            else
                w.st = necir_pkg::STATUS_INVALID;
        end
        expected_codes.push_back(w);
        sym_cnt        = '0;
        data_sr        = '0;
        frame_ok       = 1'b1;
        lead_is_repeat = 1'b0;
    endfunction

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_codes.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: status %0d addr %h cmd %h",
                         $time, status, address, command);
            end
            else
            begin
                oldest_code = expected_codes.pop_front();
                if (status !== oldest_code.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, oldest_code.st, status);
                end
                if (address !== oldest_code.addr)
                begin
                    errors++;
                    $display("%0t: address expected %h, got %h",
                             $time, oldest_code.addr, address);
                end
                if (command !== oldest_code.cmd)
                begin
                    errors++;
                    $display("%0t: command expected %h, got %h",
                             $time, oldest_code.cmd, command);
                end
            end
        end
    end

    // Result side stall: random runs, or a long counted hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0)
        begin
            res_stall = 1'b1;
            hold_cnt--;
        end
        else if (!rx_idle_en)
            res_stall = 1'b0;
        else if (rx_run > 0)
            rx_run--;
        else
        begin
            res_stall = !res_stall;
            rx_run = res_stall ? gap_len() : $urandom_range(8, 0);
        end
    end

    // Send one symbol word; entered and left at a falling edge.
    task automatic send_symbol(logic [DW-1:0] mk, logic [DW-1:0] sp, logic fe);
        int gap;
        gap = tx_idle_en ? gap_len() : 0;
        if (gap > 0)
        begin
            sym_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sym_valid = 1'b1;
        mark_us   = mk;
        space_us  = sp;
        frame_end = fe;
        @(posedge clk);
        while (sym_stall)
            @(posedge clk);
        decode_symbol(mk, sp, fe);
        symbols_sent++;
        @(negedge clk);
    endtask

    // A duration inside (hit) or outside the window around a nominal.
    function automatic logic [DW-1:0] duration_near(int nom, bit hit);
        int m;
        int r;
        int j;
        int lo;
        int hi;
        int v;
        m = int'(margin_q);
        r = $urandom_range(9, 0);
        j = $urandom_range(200, 0);
        if (hit)
        begin
            lo = (nom - m + 1 < 0) ? 0 : nom - m + 1;
            hi = nom + m - 1;
            if (hi < lo)
                v = nom;
            else if (r == 0)
                v = lo;
            else if (r == 1)
                v = hi;
            else
                v = $urandom_range(hi, lo);
        end
        else
        begin
            case (r)
                0: v = nom + m;
                1: v = (nom - m >= 0) ? nom - m : nom + m + j;
                2, 3: v = $urandom_range(DUR_MAX, 0);
                default: v = (r[0]) ? nom + m + j : nom - m - j;
            endcase
            if (v < 0)
                v = nom + m;
        end
        if (v > DUR_MAX)
            v = DUR_MAX;
        return DW'(v);
    endfunction

    function automatic logic [DW-1:0] any_duration();
        return DW'($urandom_range(DUR_MAX, 0));
    endfunction

    // Full 34-symbol frame; broken picks a symbol with bad timing, -1 for none.
    task automatic send_frame(logic [15:0] a, logic [15:0] c, int broken);
        logic [31:0] code;
        bit          hm;
        bit          hs;
        int          r;
        int          ns;
        code = {c, a};
        for (int k = 0; k <= 32; k++)
        begin
            hm = 1'b1;
            hs = 1'b1;
            if (k == broken)
            begin
                r = $urandom_range(2, 0);
                hm = (r == 1);
                hs = (r == 0);
            end
            if (k == 0)
                send_symbol(duration_near(int'(necir_pkg::LEAD_MARK), hm),
                            duration_near(int'(necir_pkg::LEAD_SPACE), hs), 1'b0);
            else
            begin
                ns = code[k-1] ? int'(necir_pkg::ONE_SPACE) : int'(necir_pkg::ZERO_SPACE);
                send_symbol(duration_near(int'(necir_pkg::BIT_MARK), hm),
                            duration_near(ns, hs), 1'b0);
            end
        end
        // The trailing symbol is not checked.
        send_symbol(any_duration(), any_duration(), 1'b1);
    endtask

    task automatic send_repeat(bit hit);
        send_symbol(duration_near(int'(necir_pkg::LEAD_MARK), 1'b1),
                    duration_near(int'(necir_pkg::REP_SPACE), hit), 1'b0);
        send_symbol(any_duration(), any_duration(), 1'b1);
    endtask

    // Frame of a given length built from plausible and random symbols.
    task automatic send_run(int len);
        int r;
        for (int k = 0; k < len; k++)
        begin
            r = $urandom_range(3, 0);
            if (r == 0)
                send_symbol(any_duration(), any_duration(), k == len - 1);
            else if (k == 0)
                send_symbol(duration_near(int'(necir_pkg::LEAD_MARK), 1'b1),
                            duration_near(r[0] ? int'(necir_pkg::LEAD_SPACE) :
                                                 int'(necir_pkg::REP_SPACE), 1'b1),
                            k == len - 1);
            else
                send_symbol(duration_near(int'(necir_pkg::BIT_MARK), 1'b1),
                            duration_near(r[0] ? int'(necir_pkg::ONE_SPACE) :
                                                 int'(necir_pkg::ZERO_SPACE), 1'b1),
                            k == len - 1);
        end
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_xfer(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {necir_pkg::REG_MARGIN, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Wait until every expected word has arrived and the pipeline is empty.
    task automatic wait_idle();
        sym_valid = 1'b0;
        while (expected_codes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_margin_read();
        logic [31:0] rd;
        apb_xfer(1'b0, '0, rd);
        if (rd !== {22'd0, margin_q})
        begin
            errors++;
            $display("%0t: margin read expected %h, got %h", $time, {22'd0, margin_q}, rd);
        end
    endtask

    task automatic set_margin(logic [necir_pkg::MARGIN_W-1:0] v);
        logic [31:0] rd;
        wait_idle();
        apb_xfer(1'b1, {22'd0, v}, rd);
        margin_q = v;
        check_margin_read();
    endtask

    // Directed frames at the reset margin.
    task automatic test_directed();
        check_margin_read();
        send_repeat(1'b1);
        send_frame(16'h0000, 16'h0000, -1);
        send_frame(16'hFFFF, 16'hFFFF, -1);
        send_frame(16'h1234, 16'hABCD, -1);
        send_repeat(1'b1);
        // Two symbols with a normal leader are not a repeat.
        send_symbol(DW'(9000), DW'(4500), 1'b0);
        send_symbol(DW'(560), DW'(560), 1'b1);
        // A broken data symbol leaves the stored code alone.
        send_frame(16'h5A5A, 16'hC3C3, 17);
        send_frame(16'h0F0F, 16'hF0F0, 0);
        send_repeat(1'b1);
        send_repeat(1'b0);
        // The window bounds are strict.
        send_symbol(DW'(8701), DW'(2250), 1'b0);
        send_symbol(DW'(0), DW'(0), 1'b1);
        send_symbol(DW'(8700), DW'(2250), 1'b0);
        send_symbol(DW'(DUR_MAX), DW'(DUR_MAX), 1'b1);
        send_symbol(DW'(DUR_MAX), DW'(0), 1'b1);
        send_symbol(DW'(0), DW'(DUR_MAX), 1'b1);
        send_run(3);
        send_run(33);
        send_run(35);
    endtask

    // Narrowest, widest and zero margins.
    task automatic test_margin_extremes();
        logic [31:0] code;
        set_margin(necir_pkg::MARGIN_W'(1));
        send_frame(16'hA5A5, 16'h0001, -1);
        send_repeat(1'b1);
        send_symbol(DW'(9001), DW'(2250), 1'b0);
        send_symbol(DW'(1), DW'(1), 1'b1);
        set_margin(necir_pkg::MARGIN_W'(559));
        send_frame(16'h8001, 16'h7FFE, -1);
        send_repeat(1'b1);
        // Wide margin: zero-length marks pass, and a space of 1100 fits both shapes.
        set_margin(necir_pkg::MARGIN_W'(1023));
        code = $urandom();
        send_symbol(DW'(9000), DW'(4500), 1'b0);
        for (int k = 0; k < 32; k++)
            send_symbol(DW'(0), code[k] ? DW'(1100) : DW'(0), 1'b0);
        send_symbol(any_duration(), any_duration(), 1'b1);
        send_frame(16'h3C3C, 16'h9669, -1);
        send_repeat(1'b1);
        // Zero margin matches nothing.
        set_margin(necir_pkg::MARGIN_W'(0));
        send_frame(16'h1111, 16'h2222, -1);
        send_repeat(1'b1);
        set_margin(necir_pkg::MARGIN_RESET);
    endtask

    // The symbol count saturates on an overlong frame.
    task automatic test_long_frame();
        send_run(130);
        send_frame(16'hBEEF, 16'hCAFE, -1);
    endtask

    // Long result hold-off while short frames keep coming.
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++)
        begin
            if (k[0])
                send_repeat($urandom_range(3, 0) != 0);
            else
                send_run($urandom_range(3, 1));
        end
        tx_idle_en = 1'b1;
    endtask

    // Random traffic in phases with different margins and idling.
    task automatic test_random();
        int target;
        int r;
        int broken;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_margin(necir_pkg::MARGIN_W'(559));
                1: set_margin(necir_pkg::MARGIN_W'(1));
                2: set_margin(necir_pkg::MARGIN_W'($urandom_range(559, 1)));
                default: set_margin(necir_pkg::MARGIN_RESET);
            endcase
            // One phase runs without gaps on either side.
            tx_idle_en = (phase != 2);
            rx_idle_en = (phase != 2);
            target = symbols_sent + RANDOM_ITEMS / 4;
            while (symbols_sent < target)
            begin
                r = $urandom_range(99, 0);
                if (r < 50)
                begin
                    broken = ($urandom_range(3, 0) == 0) ? $urandom_range(32, 0) : -1;
                    send_frame(16'($urandom()), 16'($urandom()), broken);
                end
                else if (r < 72)
                    send_repeat($urandom_range(6, 0) != 0);
                else if (r < 82)
                    send_run($urandom_range(40, 1));
                else
                    send_symbol(any_duration(), any_duration(), $urandom_range(3, 0) == 0);
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        sym_valid = 1'b0;
        mark_us   = '0;
        space_us  = '0;
        frame_end = 1'b0;
        res_stall = 1'b0;
        errors       = 0;
        cycles       = 0;
        symbols_sent = 0;
        hold_req     = 1'b0;
        hold_cnt     = 0;
        rx_run       = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        margin_q       = necir_pkg::MARGIN_RESET;
        sym_cnt        = '0;
        data_sr        = '0;
        frame_ok       = 1'b1;
        lead_is_repeat = 1'b0;
        kept_addr      = '0;
        kept_cmd       = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_margin_extremes();
        test_long_frame();
        test_backpressure();
        test_random();

        wait_idle();
        if (errors == 0)
            $display("nec_ir_frame_decoder_tb: PASS");
        else
            $display("nec_ir_frame_decoder_tb: FAIL");
        $finish;
    end

endmodule
